FILE: rtl/siit_pkg.sv
// shared types and constants of the segment inner intersection test
// no dependencies; imported by siit_orient and segment_inner_intersection_test_core
package siit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_COORDS  = 8;
    localparam int IN_DATA_W   = NUM_COORDS * COORD_WIDTH;
    localparam int OUT_DATA_W  = 8;

    // coordinate slots in the input transaction, lowest first
    localparam int IDX_A_SX = 0;
    localparam int IDX_A_SY = 1;
    localparam int IDX_A_EX = 2;
    localparam int IDX_A_EY = 3;
    localparam int IDX_B_SX = 4;
    localparam int IDX_B_SY = 5;
    localparam int IDX_B_EX = 6;
    localparam int IDX_B_EY = 7;

    // result bits in the output transaction
    localparam int BIT_INNER_CROSS  = 0;
    localparam int BIT_A_DEGENERATE = 1;
    localparam int BIT_B_DEGENERATE = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } siit_adv_t;

    typedef struct packed {
        logic pos;
        logic neg;
    } siit_sign_t;

endpackage

FILE: rtl/siit_orient.sv
// pipelined orientation sign of triangle (p1, p2, p3): differences, products, compare
// depends on siit_pkg; stage loads come from the top level pipeline control
module siit_orient (
    input  logic               clk,
    input  siit_pkg::siit_adv_t adv,
    input  siit_pkg::coord_t   p1_x,
    input  siit_pkg::coord_t   p1_y,
    input  siit_pkg::coord_t   p2_x,
    input  siit_pkg::coord_t   p2_y,
    input  siit_pkg::coord_t   p3_x,
    input  siit_pkg::coord_t   p3_y,
    output siit_pkg::siit_sign_t sign
);
    import siit_pkg::*;

    diff_t      dx21_reg, dy31_reg, dy21_reg, dx31_reg;
    diff_t      dx21_next, dy31_next, dy21_next, dx31_next;
    prod_t      prod_a_reg, prod_b_reg;
    prod_t      prod_a_next, prod_b_next;
    siit_sign_t sign_reg, sign_next;

    always_comb
    begin
        dx21_next   = diff_t'(p2_x) - diff_t'(p1_x);
        dy31_next   = diff_t'(p3_y) - diff_t'(p1_y);
        dy21_next   = diff_t'(p2_y) - diff_t'(p1_y);
        dx31_next   = diff_t'(p3_x) - diff_t'(p1_x);
        prod_a_next = prod_t'(dx21_reg) * prod_t'(dy31_reg);
        prod_b_next = prod_t'(dy21_reg) * prod_t'(dx31_reg);
        sign_next.pos = prod_a_reg > prod_b_reg;
        sign_next.neg = prod_a_reg < prod_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load1)
        begin
            dx21_reg <= dx21_next;
            dy31_reg <= dy31_next;
            dy21_reg <= dy21_next;
            dx31_reg <= dx31_next;
        end
        if (adv.load2)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (adv.load3)
        begin
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule

FILE: rtl/segment_inner_intersection_test_core.sv
// top level of the segment inner intersection test: stream ports, pipeline control
// depends on siit_pkg and siit_orient
// pipeline: input transaction to result through the registered stages differences, products, compare, result
// throughput: one segment pair per cycle while the output is not stalled, set by the fully pipelined multipliers
// a stalled output keeps its result; bubbles are squeezed out while the output waits
// reset: rst_n low empties all pipeline stages at once, no item is in flight afterwards
module segment_inner_intersection_test_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [siit_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // inner_cross, a_degenerate, b_degenerate, zero fill
    output logic [siit_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import siit_pkg::*;

    typedef struct packed {
        logic a_deg;
        logic b_deg;
        logic a_pt_ok;
        logic b_pt_ok;
    } flags_t;

    coord_t     in_c [NUM_COORDS];
    coord_t     ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    flags_t     flags_next;
    flags_t     flags1_reg, flags2_reg, flags3_reg;
    logic       v1_reg, v2_reg, v3_reg, out_v_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    siit_adv_t  adv;
    siit_sign_t sg1, sg2, sg3, sg4;
    logic [OUT_DATA_W-1:0] out_reg, out_next;
    logic       hit;

    always_comb
    begin
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            in_c[i] = coord_t'(s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    assign ax1 = in_c[IDX_A_SX];
    assign ay1 = in_c[IDX_A_SY];
    assign ax2 = in_c[IDX_A_EX];
    assign ay2 = in_c[IDX_A_EY];
    assign bx1 = in_c[IDX_B_SX];
    assign by1 = in_c[IDX_B_SY];
    assign bx2 = in_c[IDX_B_EX];
    assign by2 = in_c[IDX_B_EY];

    // degenerate flags and bounding box / endpoint checks for point segments
    always_comb
    begin
        flags_next.a_deg = (ax1 == ax2) && (ay1 == ay2);
        flags_next.b_deg = (bx1 == bx2) && (by1 == by2);
        flags_next.a_pt_ok = !((ax1 == bx1) && (ay1 == by1))
                          && !((ax1 == bx2) && (ay1 == by2))
                          && ((ax1 >= bx1) || (ax1 >= bx2))
                          && ((ax1 <= bx1) || (ax1 <= bx2))
                          && ((ay1 >= by1) || (ay1 >= by2))
                          && ((ay1 <= by1) || (ay1 <= by2));
        flags_next.b_pt_ok = !((bx1 == ax1) && (by1 == ay1))
                          && !((bx1 == ax2) && (by1 == ay2))
                          && ((bx1 >= ax1) || (bx1 >= ax2))
                          && ((bx1 <= ax1) || (bx1 <= ax2))
                          && ((by1 >= ay1) || (by1 >= ay2))
                          && ((by1 <= ay1) || (by1 <= ay2));
    end

    // each stage loads when empty or when its successor moves
    assign rdy4 = !out_v_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign adv.load1 = rdy1;
    assign adv.load2 = rdy2;
    assign adv.load3 = rdy3;

    siit_orient u_orient_ab1 (
        .clk (clk), .adv (adv),
        .p1_x (ax1), .p1_y (ay1), .p2_x (ax2), .p2_y (ay2), .p3_x (bx1), .p3_y (by1),
        .sign (sg1)
    );

    siit_orient u_orient_ab2 (
        .clk (clk), .adv (adv),
        .p1_x (ax1), .p1_y (ay1), .p2_x (ax2), .p2_y (ay2), .p3_x (bx2), .p3_y (by2),
        .sign (sg2)
    );

    siit_orient u_orient_ba1 (
        .clk (clk), .adv (adv),
        .p1_x (bx1), .p1_y (by1), .p2_x (bx2), .p2_y (by2), .p3_x (ax1), .p3_y (ay1),
        .sign (sg3)
    );

    siit_orient u_orient_ba2 (
        .clk (clk), .adv (adv),
        .p1_x (bx1), .p1_y (by1), .p2_x (bx2), .p2_y (by2), .p3_x (ax2), .p3_y (ay2),
        .sign (sg4)
    );

    always_comb
    begin
        if (flags3_reg.a_deg && flags3_reg.b_deg)
        begin
            hit = 1'b0;
        end
        else if (flags3_reg.a_deg)
        begin
            hit = flags3_reg.a_pt_ok && !sg3.pos && !sg3.neg;
        end
        else if (flags3_reg.b_deg)
        begin
            hit = flags3_reg.b_pt_ok && !sg1.pos && !sg1.neg;
        end
        else
        begin
            hit = ((sg1.pos && sg2.neg) || (sg1.neg && sg2.pos))
               && ((sg3.pos && sg4.neg) || (sg3.neg && sg4.pos));
        end
        out_next                   = '0;
        out_next[BIT_INNER_CROSS]  = hit;
        out_next[BIT_A_DEGENERATE] = flags3_reg.a_deg;
        out_next[BIT_B_DEGENERATE] = flags3_reg.b_deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                out_v_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            flags1_reg <= flags_next;
        end
        if (rdy2)
        begin
            flags2_reg <= flags1_reg;
        end
        if (rdy3)
        begin
            flags3_reg <= flags2_reg;
        end
        if (rdy4)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    a_cross_not_both_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[BIT_INNER_CROSS])
            |-> !(m_axis_tdata[BIT_A_DEGENERATE] && m_axis_tdata[BIT_B_DEGENERATE]))
        else $error("inner cross reported for two point segments");

    a_ready_when_sink_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_empty_stage_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_axis_tready)
        else $error("empty first stage refuses a transaction");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> m_axis_tvalid)
        else $error("result lost between compare stage and output");

endmodule
